// File: sv/bpd_pkg.sv
`timescale 1ns / 1ps

package bpd_pkg;

    localparam int BYTE_W        = 8;
    localparam int MASK_W        = 16;
    localparam int CRC_W         = 16;
    localparam int EVENT_W       = 2;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int NUM_COMMANDS  = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PREAMBLE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HANDLER_MASK = 2'd1;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_CMD     = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC_HI  = 3'd4,
        PH_CRC_LO  = 3'd5
    } phase_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE     = 2'd0,
        EV_PAYLOAD  = 2'd1,
        EV_COMPLETE = 2'd2
    } event_t;

    typedef struct packed {
        event_t             ev;
        logic [BYTE_W-1:0]  payload_byte;
        logic [BYTE_W-1:0]  payload_index;
        logic               last_payload;
        logic [BYTE_W-1:0]  command_code;
        logic [BYTE_W-1:0]  payload_length;
        logic [CRC_W-1:0]   received_crc;
        logic               dispatch;
        logic               busy;
    } result_t;

endpackage

// File: sv/bpd_step.sv
`timescale 1ns / 1ps

// per-byte framing state machine and result decode
module bpd_step
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [bpd_pkg::BYTE_W-1:0]    byte_in,
    input  logic [bpd_pkg::BYTE_W-1:0]    preamble,
    input  logic [bpd_pkg::MASK_W-1:0]    handler_mask,
    output bpd_pkg::result_t              result
);

    bpd_pkg::phase_t              phase_reg, phase_next;
    logic [bpd_pkg::BYTE_W-1:0]   cmd_reg, cmd_next;
    logic [bpd_pkg::BYTE_W-1:0]   len_reg, len_next;
    logic [bpd_pkg::BYTE_W-1:0]   cnt_reg, cnt_next;
    logic [bpd_pkg::BYTE_W-1:0]   crc_hi_reg, crc_hi_next;
    logic                         is_last;
    logic                         cmd_ok;

    assign is_last = ({1'b0, cnt_reg} + 9'd1) >= {1'b0, len_reg};
    assign cmd_ok  = (32'(cmd_reg) < bpd_pkg::NUM_COMMANDS) && (cmd_reg < 8'd16)
                     && handler_mask[cmd_reg[3:0]];

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            bpd_pkg::PH_IDLE:
            begin
                if (byte_in == preamble)
                    phase_next = bpd_pkg::PH_CMD;
            end
            bpd_pkg::PH_CMD:     phase_next = bpd_pkg::PH_LEN;
            bpd_pkg::PH_LEN:
            begin
                // zero length skips the payload
                phase_next = (byte_in == '0) ? bpd_pkg::PH_CRC_HI : bpd_pkg::PH_PAYLOAD;
            end
            bpd_pkg::PH_PAYLOAD:
            begin
                if (is_last)
                    phase_next = bpd_pkg::PH_CRC_HI;
            end
            bpd_pkg::PH_CRC_HI:  phase_next = bpd_pkg::PH_CRC_LO;
            bpd_pkg::PH_CRC_LO:  phase_next = bpd_pkg::PH_IDLE;
            default:             phase_next = bpd_pkg::PH_IDLE;
        endcase
    end

    // datapath registers and result
    always_comb
    begin
        cmd_next    = cmd_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        crc_hi_next = crc_hi_reg;
        result      = '0;
        result.ev   = bpd_pkg::EV_NONE;
        unique case (phase_reg)
            bpd_pkg::PH_IDLE:    ;
            bpd_pkg::PH_CMD:     cmd_next = byte_in;
            bpd_pkg::PH_LEN:
            begin
                len_next = byte_in;
                cnt_next = '0;
            end
            bpd_pkg::PH_PAYLOAD:
            begin
                result.ev            = bpd_pkg::EV_PAYLOAD;
                result.payload_byte  = byte_in;
                result.payload_index = cnt_reg;
                result.last_payload  = is_last;
                cnt_next             = cnt_reg + 8'd1;
            end
            bpd_pkg::PH_CRC_HI:  crc_hi_next = byte_in;
            bpd_pkg::PH_CRC_LO:
            begin
                result.ev           = bpd_pkg::EV_COMPLETE;
                result.received_crc = {crc_hi_reg, byte_in};
                result.dispatch     = cmd_ok;
            end
            default:
            begin
                // unused phase code: clear everything
                cmd_next    = '0;
                len_next    = '0;
                cnt_next    = '0;
                crc_hi_next = '0;
            end
        endcase
        result.command_code   = cmd_next;
        result.payload_length = len_next;
        result.busy           = (phase_next != bpd_pkg::PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= bpd_pkg::PH_IDLE;
            cmd_reg    <= '0;
            len_reg    <= '0;
            cnt_reg    <= '0;
            crc_hi_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            cmd_reg    <= cmd_next;
            len_reg    <= len_next;
            cnt_reg    <= cnt_next;
            crc_hi_reg <= crc_hi_next;
        end
    end

endmodule

// File: sv/bpd_out_reg.sv
`timescale 1ns / 1ps

// result register with valid/ready toward the receiver
module bpd_out_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_valid,
    output logic              load_ready,
    input  bpd_pkg::result_t  load_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bpd_pkg::result_t  out_data
);

    logic              valid_reg;
    bpd_pkg::result_t  data_reg;

    assign load_ready = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load_ready)
            valid_reg <= load_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load_ready && load_valid)
            data_reg <= load_data;
    end

endmodule

// File: sv/byte_packet_deframer.sv
`timescale 1ns / 1ps

// byte packet deframer
// frame: preamble, command, length, length payload bytes, crc high, crc low
// input channel (in_valid/in_ready, rx_byte): one received byte per transfer
// output channel (out_valid/out_ready): exactly one result per input byte;
//   event_res says nothing, payload byte (with index and last flag) or
//   packet complete (with command, length, crc and dispatch flag)
// config channel (cfg_valid/cfg_ready): cfg_index 0 preamble byte,
//   1 handler mask; other indexes are dropped; always ready, write only
//   while no byte is in flight
// path: a taken byte lands in the input register; its result is loaded
//   into the output register as soon as that register can take it
// throughput: one byte per cycle while results are taken; framing state is a
//   combinational update between the input register and the result register
// reset: back to waiting for the preamble, both config registers zero
// receiver stall: the result register holds; the input register keeps
//   one more byte, then in_ready drops until the receiver takes a result
module byte_packet_deframer
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [bpd_pkg::BYTE_W-1:0]         rx_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [bpd_pkg::EVENT_W-1:0]        event_res,
    output logic [bpd_pkg::BYTE_W-1:0]         payload_byte,
    output logic [bpd_pkg::BYTE_W-1:0]         payload_index,
    output logic                               last_payload,
    output logic [bpd_pkg::BYTE_W-1:0]         command_code,
    output logic [bpd_pkg::BYTE_W-1:0]         payload_length,
    output logic [bpd_pkg::CRC_W-1:0]          received_crc,
    output logic                               dispatch,
    output logic                               busy_res,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // config registers
    logic [bpd_pkg::BYTE_W-1:0]  preamble_reg;
    logic [bpd_pkg::MASK_W-1:0]  mask_reg;

    // input register
    logic                        in_valid_reg;
    logic [bpd_pkg::BYTE_W-1:0]  in_byte_reg;

    logic                        load_ready;
    logic                        advance;
    bpd_pkg::result_t            step_result;
    bpd_pkg::result_t            out_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preamble_reg <= '0;
            mask_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == bpd_pkg::CFG_PREAMBLE)
                preamble_reg <= cfg_data[bpd_pkg::BYTE_W-1:0];
            else if (cfg_index == bpd_pkg::CFG_HANDLER_MASK)
                mask_reg <= cfg_data;
        end
    end

    // the held byte steps the state machine when the result register frees up
    assign advance  = in_valid_reg && load_ready;
    assign in_ready = !in_valid_reg || load_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_byte_reg <= rx_byte;
    end

    bpd_step u_step
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .byte_in      (in_byte_reg),
        .preamble     (preamble_reg),
        .handler_mask (mask_reg),
        .result       (step_result)
    );

    bpd_out_reg u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (in_valid_reg),
        .load_ready (load_ready),
        .load_data  (step_result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign event_res      = bpd_pkg::EVENT_W'(out_data.ev);
    assign payload_byte   = out_data.payload_byte;
    assign payload_index  = out_data.payload_index;
    assign last_payload   = out_data.last_payload;
    assign command_code   = out_data.command_code;
    assign payload_length = out_data.payload_length;
    assign received_crc   = out_data.received_crc;
    assign dispatch       = out_data.dispatch;
    assign busy_res       = out_data.busy;

endmodule

// File: sv/bpd_checker.sv
`timescale 1ns / 1ps

module bpd_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [bpd_pkg::EVENT_W-1:0]   event_res,
    input  logic [bpd_pkg::BYTE_W-1:0]    payload_byte,
    input  logic [bpd_pkg::BYTE_W-1:0]    payload_index,
    input  logic                          last_payload,
    input  logic [bpd_pkg::BYTE_W-1:0]    payload_length,
    input  logic [bpd_pkg::CRC_W-1:0]     received_crc,
    input  logic                          busy_res
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res)
        && $stable(payload_byte) && $stable(received_crc))
        else $error("result changed while stalled");

    // a payload byte is always followed by more of the frame
    a_payload_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == bpd_pkg::EV_PAYLOAD |-> busy_res)
        else $error("payload byte reported outside a packet");

    // completion ends the packet
    a_complete_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == bpd_pkg::EV_COMPLETE |-> !busy_res)
        else $error("packet complete but still busy");

    // last payload byte sits at length minus one
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_payload |->
        event_res == bpd_pkg::EV_PAYLOAD && payload_index == payload_length - 8'd1)
        else $error("last payload flag at wrong index");

endmodule

bind byte_packet_deframer bpd_checker u_bpd_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_res      (event_res),
    .payload_byte   (payload_byte),
    .payload_index  (payload_index),
    .last_payload   (last_payload),
    .payload_length (payload_length),
    .received_crc   (received_crc),
    .busy_res       (busy_res)
);
